@@ rtl/los_pkg.sv @@
// ----------------------------------------------------------------------------
// los_pkg
// Shared widths, constants and defaults for the line-of-sight clearance block.
// ----------------------------------------------------------------------------
`default_nettype none

package los_pkg;

  // default profile capacity
  localparam int unsigned LOS_MAX_SAMPLES = 1024;

  // field widths
  localparam int unsigned ELEV_W     = 18;  // elevation sample, signed
  localparam int unsigned ANT_W      = 16;  // antenna height, unsigned
  localparam int unsigned OUT_IDX_W  = 11;  // worst index, signed
  localparam int unsigned OUT_CLR_W  = 20;  // min clearance, signed
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_TDATA_W  = 32;

  // end heights and their difference
  localparam int unsigned H_W    = ELEV_W + 1;  // antenna + sample
  localparam int unsigned DIFF_W = H_W + 1;     // h1 - h2
  localparam int unsigned MAG_W  = H_W;         // |h1 - h2|
  localparam int unsigned FRAC_W = 16;          // extra fraction bits
  localparam int unsigned DIVD_W = MAG_W + FRAC_W;

  // sight line / clearance accumulator, 16 extra fraction bits
  localparam int unsigned ACC_W = 38;

  // 99999 m in 1/16 m with 16 fraction bits
  localparam logic signed [ACC_W-1:0] START_MIN = 38'sd104856551424;

  localparam logic signed [OUT_IDX_W-1:0] CLEAR_INDEX     = -11'sd2;
  localparam logic signed [OUT_CLR_W-1:0] CLEAR_CLEARANCE = -20'sd32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TX_HEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RX_HEIGHT = 8'd1;

endpackage

`default_nettype wire

@@ rtl/los_ram.sv @@
// ----------------------------------------------------------------------------
// los_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module los_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/los_div.sv @@
// ----------------------------------------------------------------------------
// los_div
// Unsigned restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module los_div #(
  parameter int unsigned DIVD_W = 35,
  parameter int unsigned DIVS_W = 11
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire  [DIVD_W-1:0]  dividend_i,
  input  wire  [DIVS_W-1:0]  divisor_i,
  output logic               done_o,
  output logic [DIVD_W-1:0]  quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVD_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [DIVS_W:0]   trial;
  logic              ge;

  // shift next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVD_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
      quo_d = {quo_q[DIVD_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ rtl/line_of_sight_clearance.sv @@
// ----------------------------------------------------------------------------
// line_of_sight_clearance
// Stores a terrain profile, then walks it against the straight sight line and
// reports the worst clearance when terrain blocks the path, else fixed clear codes.
// ----------------------------------------------------------------------------
// Loading: one sample per cycle, no result for ordinary samples.
// After the last sample: the divider start is registered, the slope divider
// runs, the profile RAM is walked at one read per cycle, then the result goes
// to the output register, which waits while a previous result is not taken.
// Input is held off from the last sample until the result is registered.
// Reset clears control state and both antenna heights; the RAM is not cleared.
`default_nettype none

module line_of_sight_clearance #(
  parameter int unsigned MAX_SAMPLES = los_pkg::LOS_MAX_SAMPLES
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration write channel
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [los_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [los_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // profile samples
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [los_pkg::S_TDATA_W-1:0]       s_axis_tdata,  // [17:0] elevation_sample
  input  wire                                 s_axis_tlast,  // last_sample
  // results
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [los_pkg::M_TDATA_W-1:0]       m_axis_tdata,  // [10:0] worst_index,
                                                             // [30:11] min_clearance
  output logic                                m_axis_tuser   // blocked
);

  import los_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [ANT_W-1:0] tx_q, rx_q;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [ELEV_W-1:0] first_q, first_d;
  logic [ELEV_W-1:0] last_q, last_d;

  logic signed [H_W-1:0]    h1_q, h1_d;
  logic                     neg_q, neg_d;
  logic [MAG_W-1:0]         mag_q, mag_d;
  logic                     div_start_q, div_start_d;
  logic                     div_done;
  logic [DIVD_W-1:0]        quotient;

  logic signed [ACC_W-1:0]  slope_q, slope_d;
  logic signed [ACC_W-1:0]  line_q, line_d;
  logic signed [ACC_W-1:0]  min_q, min_d;
  logic [IDX_W-1:0]         min_idx_q, min_idx_d;
  logic [CNT_W-1:0]         ra_q, ra_d;
  logic [CNT_W-1:0]         rj_q, rj_d;
  logic                     rvalid_q, rvalid_d;

  logic                     out_valid_q, out_valid_d;
  logic                     out_blk_q, out_blk_d;
  logic [OUT_IDX_W-1:0]     out_idx_q, out_idx_d;
  logic [OUT_CLR_W-1:0]     out_clr_q, out_clr_d;

  logic                     in_xfer;
  logic                     store;
  logic signed [ELEV_W-1:0] sample;
  logic signed [ELEV_W-1:0] first_val, last_val;
  logic signed [H_W-1:0]    h1_new, h2_new;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] diff_abs;

  logic                     ram_re;
  logic [ELEV_W-1:0]        ram_rdata;
  logic signed [ACC_W-1:0]  clearance;
  logic signed [ACC_W-1:0]  min_floor;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q <= '0;
      rx_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TX_HEIGHT: tx_q <= cfg_data_i;
        REG_RX_HEIGHT: rx_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // loading
  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign sample        = $signed(s_axis_tdata[ELEV_W-1:0]);
  assign store         = count_q < CNT_W'(MAX_SAMPLES);

  // end heights as they stand after this sample
  assign first_val = (count_q == '0) ? sample : $signed(first_q);
  assign last_val  = store ? sample : $signed(last_q);
  assign h1_new    = H_W'($signed({1'b0, tx_q})) + H_W'(first_val);
  assign h2_new    = H_W'($signed({1'b0, rx_q})) + H_W'(last_val);
  assign diff      = DIFF_W'(h1_new) - DIFF_W'(h2_new);
  assign diff_abs  = diff[DIFF_W-1] ? -diff : diff;

  los_ram #(
    .WIDTH (ELEV_W),
    .DEPTH (MAX_SAMPLES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer && store),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (s_axis_tdata[ELEV_W-1:0]),
    .re_i    (ram_re),
    .raddr_i (ra_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  los_div #(
    .DIVD_W (DIVD_W),
    .DIVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i ({mag_q, FRAC_W'(0)}),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // walk datapath
  assign ram_re    = (state_q == ST_WALK) && (ra_q < n_q);
  assign clearance = line_q - (ACC_W'($signed(ram_rdata)) <<< FRAC_W);
  assign min_floor = min_q >>> FRAC_W;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    first_d     = first_q;
    last_d      = last_q;
    h1_d        = h1_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    div_start_d = 1'b0;
    slope_d     = slope_q;
    line_d      = line_q;
    min_d       = min_q;
    min_idx_d   = min_idx_q;
    ra_d        = ra_q;
    rj_d        = rj_q;
    rvalid_d    = 1'b0;
    out_valid_d = out_valid_q;
    out_blk_d   = out_blk_q;
    out_idx_d   = out_idx_q;
    out_clr_d   = out_clr_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (store) begin
            count_d = count_q + 1'b1;
            last_d  = s_axis_tdata[ELEV_W-1:0];
            if (count_q == '0) begin
              first_d = s_axis_tdata[ELEV_W-1:0];
            end
          end
          if (s_axis_tlast) begin
            n_d         = store ? count_q + 1'b1 : count_q;
            count_d     = '0;
            h1_d        = h1_new;
            neg_d       = diff[DIFF_W-1];
            mag_d       = diff_abs[MAG_W-1:0];
            div_start_d = 1'b1;
            state_d     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          slope_d   = neg_q ? -ACC_W'(quotient) : ACC_W'(quotient);
          line_d    = ACC_W'(h1_q) <<< FRAC_W;
          min_d     = START_MIN;
          min_idx_d = '0;
          ra_d      = '0;
          state_d   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (ram_re) begin
          ra_d     = ra_q + 1'b1;
          rj_d     = ra_q;
          rvalid_d = 1'b1;
        end
        if (rvalid_q) begin
          // strict compare keeps the first index on ties
          if (clearance < min_q) begin
            min_d     = clearance;
            min_idx_d = rj_q[IDX_W-1:0];
          end
          line_d = line_q - slope_q;
          if (rj_q + 1'b1 == n_q) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_blk_d   = min_q[ACC_W-1];
          if (min_q[ACC_W-1]) begin
            out_idx_d = OUT_IDX_W'(min_idx_q);
            out_clr_d = min_floor[OUT_CLR_W-1:0];
          end else begin
            out_idx_d = CLEAR_INDEX;
            out_clr_d = CLEAR_CLEARANCE;
          end
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      div_start_q <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      div_start_q <= div_start_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    first_q   <= first_d;
    last_q    <= last_d;
    h1_q      <= h1_d;
    neg_q     <= neg_d;
    mag_q     <= mag_d;
    slope_q   <= slope_d;
    line_q    <= line_d;
    min_q     <= min_d;
    min_idx_q <= min_idx_d;
    ra_q      <= ra_d;
    rj_q      <= rj_d;
    out_blk_q <= out_blk_d;
    out_idx_q <= out_idx_d;
    out_clr_q <= out_clr_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_blk_q;
  assign m_axis_tdata  = {1'b0, out_clr_q, out_idx_q};

endmodule

`default_nettype wire
